FILE: sv/lps_pkg.sv
package lps_pkg;

   // Fixed arithmetic constants of the steering law
   localparam int NORM_FULL      = 1000;
   localparam int NORM_BITS      = 10;
   localparam int SEEN_LEVEL     = 400;
   localparam int LOST_ERROR     = 6400;   // 25.0 in Q8
   localparam int INTEGRAL_LIMIT = 7680;   // 30.0 in Q8
   localparam int POS_SCALE      = 2560;   // 10 * 256

   localparam int RAW_CFG_BITS   = 12;
   localparam int DUTY_BITS      = 7;
   localparam int GAIN_BITS      = 8;
   localparam int ERR_OUT_BITS   = 14;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;
   localparam int RSP_DATA_BITS  =
      ((2 * DUTY_BITS + ERR_OUT_BITS + 7) / 8) * 8;

   localparam logic [RAW_CFG_BITS-1:0] RAW_LOW_RESET  = 12'd1700;
   localparam logic [RAW_CFG_BITS-1:0] RAW_HIGH_RESET = 12'd4000;
   localparam logic [DUTY_BITS-1:0]    BASE_RESET     = 7'd75;
   localparam logic [DUTY_BITS-1:0]    DMIN_RESET     = 7'd65;
   localparam logic [DUTY_BITS-1:0]    DMAX_RESET     = 7'd85;
   localparam logic [GAIN_BITS-1:0]    GAIN_P_RESET   = 8'd16;
   localparam logic [GAIN_BITS-1:0]    GAIN_I_RESET   = 8'd0;
   localparam logic [GAIN_BITS-1:0]    GAIN_D_RESET   = 8'd24;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RAW_LOW,
      CSR_RAW_HIGH,
      CSR_BASE_DUTY,
      CSR_DUTY_MIN,
      CSR_DUTY_MAX,
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM_CHECK,
      ST_NORM_DIV,
      ST_NORM_ACC,
      ST_POS_CHECK,
      ST_POS_DIV,
      ST_ERR,
      ST_MAC_P,
      ST_MAC_I,
      ST_MAC_D,
      ST_DUTY,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MAC_P,
      MAC_I,
      MAC_D
   } mac_sel_type;

   typedef struct packed {
      logic        capture;
      logic        norm_check;
      logic        div_step;
      logic        norm_acc;
      logic        pos_load;
      logic        err_load;
      logic        mac_en;
      mac_sel_type mac_sel;
      logic        duty_load;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic norm_trivial;
      logic last_sensor;
      logic sum_zero;
   } sts_type;

endpackage

FILE: sv/lps_div.sv
module lps_div #(
   parameter int RW = 25,
   parameter int QW = 13
) (
   input  logic          clock,
   input  logic          load,
   input  logic          step,
   input  logic [RW-1:0] dividend,
   input  logic [RW-1:0] divisor_sh,
   output logic [QW-1:0] quotient
);
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dsh_ff, dsh_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          ge;

   // restoring division, one quotient bit per step; divisor is preshifted
   // so that the dividend is known to be below twice its first position
   always_comb begin
      ge     = rem_ff >= dsh_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (load) begin
         rem_in = dividend;
         dsh_in = divisor_sh;
         quo_in = '0;
      end else if (step) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

FILE: sv/lps_ctrl.sv
module lps_ctrl #(
   parameter int POS_STEPS = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  lps_pkg::sts_type sts,
   output lps_pkg::cmd_type cmd
);
   import lps_pkg::*;

   localparam int STEPS_MAX = (POS_STEPS > NORM_BITS) ? POS_STEPS : NORM_BITS;
   localparam int CNTW      = $clog2(STEPS_MAX);

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_NORM_CHECK;
            end
         end
         ST_NORM_CHECK: begin
            cmd.norm_check = 1'b1;
            cnt_in         = '0;
            if (!sts.norm_trivial) begin
               state_in = ST_NORM_DIV;
            end else if (sts.last_sensor) begin
               state_in = ST_POS_CHECK;
            end
         end
         ST_NORM_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NORM_BITS - 1)) begin
               state_in = ST_NORM_ACC;
            end
         end
         ST_NORM_ACC: begin
            cmd.norm_acc = 1'b1;
            state_in     = sts.last_sensor ? ST_POS_CHECK : ST_NORM_CHECK;
         end
         ST_POS_CHECK: begin
            cmd.pos_load = 1'b1;
            cnt_in       = '0;
            state_in     = sts.sum_zero ? ST_ERR : ST_POS_DIV;
         end
         ST_POS_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(POS_STEPS - 1)) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.err_load = 1'b1;
            state_in     = ST_MAC_P;
         end
         ST_MAC_P: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_P;
            state_in    = ST_MAC_I;
         end
         ST_MAC_I: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_I;
            state_in    = ST_MAC_D;
         end
         ST_MAC_D: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_D;
            state_in    = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.duty_load = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            // wait here until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while a transfer is pending");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.norm_check, cmd.div_step, cmd.norm_acc, cmd.pos_load,
                cmd.err_load, cmd.mac_en, cmd.duty_load, cmd.emit}))
      else $error("more than one datapath command in a cycle");

endmodule

FILE: sv/lps_dp.sv
module lps_dp #(
   parameter int SENSOR_COUNT = 4,
   parameter int SAMPLE_BITS  = 12,
   parameter int POS_QBITS    = 13
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [SENSOR_COUNT*SAMPLE_BITS-1:0]    sensors,
   input  logic                                   csr_write,
   input  logic [lps_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lps_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  lps_pkg::cmd_type                       cmd,
   output lps_pkg::sts_type                       sts,
   output logic [lps_pkg::DUTY_BITS-1:0]          left_duty,
   output logic [lps_pkg::DUTY_BITS-1:0]          right_duty,
   output logic [lps_pkg::ERR_OUT_BITS-1:0]       position_error,
   output logic                                   line_lost
);
   import lps_pkg::*;

   localparam int IDXW = $clog2(SENSOR_COUNT);
   localparam int CMPW = (SAMPLE_BITS > RAW_CFG_BITS) ? SAMPLE_BITS : RAW_CFG_BITS;
   localparam int SUMW = $clog2(NORM_FULL * SENSOR_COUNT + 1);
   localparam int MAGW = $clog2(NORM_FULL * SENSOR_COUNT * SENSOR_COUNT / 2 + 1);
   localparam int WSW  = MAGW + 1;
   localparam int WTW  = $clog2(SENSOR_COUNT) + 2;
   localparam int DVSW = (SUMW > RAW_CFG_BITS) ? SUMW : RAW_CFG_BITS;
   localparam int QW   = (POS_QBITS > NORM_BITS) ? POS_QBITS : NORM_BITS;
   localparam int RW   = DVSW + QW;
   localparam int NUMW = RAW_CFG_BITS + NORM_BITS;
   localparam int DNW  = MAGW + 12;
   localparam int EW   = (POS_QBITS + 1 > ERR_OUT_BITS) ? POS_QBITS + 1 : ERR_OUT_BITS;
   localparam int PW   = EW + GAIN_BITS + 2;
   localparam int AW   = PW + 2;
   localparam int DTW  = AW + 1;

   localparam logic signed [EW-1:0] LOST_POS  = EW'(LOST_ERROR);
   localparam logic signed [EW-1:0] LOST_NEG  = EW'(-LOST_ERROR);
   localparam logic signed [EW:0]   ILIM_POS  = (EW + 1)'(INTEGRAL_LIMIT);
   localparam logic signed [EW:0]   ILIM_NEG  = (EW + 1)'(-INTEGRAL_LIMIT);

   // configuration
   logic [RAW_CFG_BITS-1:0] raw_low_ff, raw_high_ff;
   logic [DUTY_BITS-1:0]    base_ff, dmin_ff, dmax_ff;
   logic [GAIN_BITS-1:0]    gain_p_ff, gain_i_ff, gain_d_ff;

   // per-item working registers
   logic [SENSOR_COUNT*SAMPLE_BITS-1:0] sample_ff;
   logic [IDXW-1:0]                     idx_ff;
   logic [SUMW-1:0]                     sum_ff;
   logic signed [WSW-1:0]               wsum_ff;
   logic                                seen_ff;
   logic signed [EW-1:0]                err_ff, integ_new_ff;
   logic signed [EW:0]                  diff_ff;
   logic signed [AW-1:0]                acc_ff;
   logic [DUTY_BITS-1:0]                left_ff, right_ff;

   // loop state
   logic signed [EW-1:0] prev_ff, integ_ff;

   // result register
   logic [DUTY_BITS-1:0]    out_left_ff, out_right_ff;
   logic [ERR_OUT_BITS-1:0] out_err_ff;
   logic                    out_lost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_low_ff  <= RAW_LOW_RESET;
         raw_high_ff <= RAW_HIGH_RESET;
         base_ff     <= BASE_RESET;
         dmin_ff     <= DMIN_RESET;
         dmax_ff     <= DMAX_RESET;
         gain_p_ff   <= GAIN_P_RESET;
         gain_i_ff   <= GAIN_I_RESET;
         gain_d_ff   <= GAIN_D_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_RAW_LOW:   raw_low_ff  <= csr_data[RAW_CFG_BITS-1:0];
            CSR_RAW_HIGH:  raw_high_ff <= csr_data[RAW_CFG_BITS-1:0];
            CSR_BASE_DUTY: base_ff     <= csr_data[DUTY_BITS-1:0];
            CSR_DUTY_MIN:  dmin_ff     <= csr_data[DUTY_BITS-1:0];
            CSR_DUTY_MAX:  dmax_ff     <= csr_data[DUTY_BITS-1:0];
            CSR_GAIN_P:    gain_p_ff   <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_I:    gain_i_ff   <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_D:    gain_d_ff   <= csr_data[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // normalization of the current sensor
   logic [SAMPLE_BITS-1:0]  raw;
   logic [CMPW-1:0]         raw_c, low_c, high_c;
   logic                    calib_ok, triv;
   logic [NORM_BITS-1:0]    triv_n, n_acc;
   logic [RAW_CFG_BITS-1:0] span, diff_raw;
   logic [NUMW-1:0]         norm_num;
   logic                    acc_en;
   logic signed [WTW-1:0]   wt;
   logic signed [WTW+NORM_BITS:0] wprod;

   assign raw      = sample_ff[idx_ff*SAMPLE_BITS +: SAMPLE_BITS];
   assign raw_c    = CMPW'(raw);
   assign low_c    = CMPW'(raw_low_ff);
   assign high_c   = CMPW'(raw_high_ff);
   assign calib_ok = raw_high_ff > raw_low_ff;
   assign triv     = !calib_ok || (raw_c <= low_c) || (raw_c >= high_c);
   assign triv_n   = (calib_ok && raw_c > low_c) ? NORM_BITS'(NORM_FULL) : '0;
   assign span     = raw_high_ff - raw_low_ff;
   // only used when low < raw < high, so raw fits the calibration width
   assign diff_raw = RAW_CFG_BITS'(raw_c - low_c);
   assign norm_num = NUMW'(diff_raw) * NUMW'(NORM_FULL);

   // shared divider
   logic [MAGW-1:0] mag;
   logic [DNW-1:0]  pos_num;
   logic [RW-1:0]   div_dividend, div_divisor;
   logic            div_load;
   logic [QW-1:0]   div_q;

   assign mag     = wsum_ff[WSW-1] ? MAGW'(-wsum_ff) : MAGW'(wsum_ff);
   assign pos_num = (DNW'(mag) << 11) + (DNW'(mag) << 9);

   always_comb begin
      div_load     = cmd.pos_load || (cmd.norm_check && !triv);
      div_dividend = RW'(norm_num);
      div_divisor  = RW'(span) << (NORM_BITS - 1);
      if (cmd.pos_load) begin
         div_dividend = RW'(pos_num);
         div_divisor  = RW'(sum_ff) << (POS_QBITS - 1);
      end
   end

   lps_div #(
      .RW (RW),
      .QW (QW)
   ) u_div (
      .clock      (clock),
      .load       (div_load),
      .step       (cmd.div_step),
      .dividend   (div_dividend),
      .divisor_sh (div_divisor),
      .quotient   (div_q)
   );

   assign n_acc  = cmd.norm_check ? triv_n : div_q[NORM_BITS-1:0];
   assign acc_en = (cmd.norm_check && triv) || cmd.norm_acc;
   assign wt     = WTW'(SENSOR_COUNT - 1) - WTW'({idx_ff, 1'b0});
   assign wprod  = wt * $signed({1'b0, n_acc});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sensors;
         idx_ff    <= '0;
         sum_ff    <= '0;
         wsum_ff   <= '0;
         seen_ff   <= 1'b0;
      end else if (acc_en) begin
         sum_ff  <= sum_ff + SUMW'(n_acc);
         wsum_ff <= wsum_ff + WSW'(wprod);
         seen_ff <= seen_ff || (n_acc > NORM_BITS'(SEEN_LEVEL));
         if (!sts.last_sensor) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   assign sts.norm_trivial = triv;
   assign sts.last_sensor  = idx_ff == IDXW'(SENSOR_COUNT - 1);
   assign sts.sum_zero     = sum_ff == '0;

   // position error, integral, derivative
   logic signed [EW-1:0] qs, err_calc;
   logic signed [EW:0]   isum;

   always_comb begin
      qs = $signed({1'b0, (EW - 1)'(div_q[POS_QBITS-1:0])});
      if (sts.sum_zero) begin
         err_calc = '0;
      end else begin
         err_calc = wsum_ff[WSW-1] ? -qs : qs;
      end
      if (!seen_ff) begin
         err_calc = (prev_ff > 0) ? LOST_POS : LOST_NEG;
      end
      isum = (EW + 1)'(integ_ff) + (EW + 1)'(err_calc);
      if (isum > ILIM_POS) begin
         isum = ILIM_POS;
      end else if (isum < ILIM_NEG) begin
         isum = ILIM_NEG;
      end
   end

   // one multiplier shared by the three PID terms
   logic [GAIN_BITS-1:0]  gsel;
   logic signed [EW:0]    vsel;
   logic signed [PW-1:0]  prod;

   always_comb begin
      case (cmd.mac_sel)
         MAC_P: begin
            gsel = gain_p_ff;
            vsel = (EW + 1)'(err_ff);
         end
         MAC_I: begin
            gsel = gain_i_ff;
            vsel = (EW + 1)'(integ_new_ff);
         end
         MAC_D: begin
            gsel = gain_d_ff;
            vsel = diff_ff;
         end
         default: begin
            gsel = '0;
            vsel = '0;
         end
      endcase
      prod = $signed({1'b0, gsel}) * vsel;
   end

   // duty clamp, lower bound first
   function automatic logic [DUTY_BITS-1:0] duty_of(input logic signed [DTW-1:0] x,
                                                    input logic signed [DTW-1:0] lo,
                                                    input logic signed [DTW-1:0] hi);
      logic signed [DTW-1:0] c;
      begin
         if (x < lo) begin
            c = lo;
         end else if (x > hi) begin
            c = hi;
         end else begin
            c = x;
         end
         return c[DUTY_BITS+7:8];
      end
   endfunction

   logic signed [AW-1:0]  corr;
   logic signed [DTW-1:0] base_w, lo_w, hi_w, left_v, right_v;

   assign corr    = acc_ff >>> 4;
   assign base_w  = $signed(DTW'({base_ff, 8'b0}));
   assign lo_w    = $signed(DTW'({dmin_ff, 8'b0}));
   assign hi_w    = $signed(DTW'({dmax_ff, 8'b0}));
   assign left_v  = base_w - DTW'(corr);
   assign right_v = base_w + DTW'(corr);

   always_ff @(posedge clock) begin
      if (cmd.err_load) begin
         err_ff       <= err_calc;
         integ_new_ff <= EW'(isum);
         diff_ff      <= (EW + 1)'(err_calc) - (EW + 1)'(prev_ff);
      end
      if (cmd.mac_en) begin
         if (cmd.mac_sel == MAC_P) begin
            acc_ff <= AW'(prod);
         end else begin
            acc_ff <= acc_ff + AW'(prod);
         end
      end
      if (cmd.duty_load) begin
         left_ff  <= duty_of(left_v, lo_w, hi_w);
         right_ff <= duty_of(right_v, lo_w, hi_w);
      end
      if (cmd.emit) begin
         out_left_ff  <= left_ff;
         out_right_ff <= right_ff;
         out_err_ff   <= ERR_OUT_BITS'(err_ff);
         out_lost_ff  <= !seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
      end else if (cmd.emit) begin
         prev_ff  <= err_ff;
         integ_ff <= integ_new_ff;
      end
   end

   assign left_duty      = out_left_ff;
   assign right_duty     = out_right_ff;
   assign position_error = out_err_ff;
   assign line_lost      = out_lost_ff;

   a_seen_sum: assert property (@(posedge clock) disable iff (reset)
      (seen_ff && !cmd.capture) |-> (sum_ff != '0))
      else $error("sensor above threshold but normalized sum is zero");

   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= $signed(EW'(INTEGRAL_LIMIT))) &&
      (integ_ff >= $signed(EW'(-INTEGRAL_LIMIT))))
      else $error("error integral outside its clamp");

endmodule

FILE: sv/line_sensor_pid_steering_unit.sv
// Line-follower steering unit. One request transfer carries SENSOR_COUNT raw
// readings; each is scaled to 0..1000 between raw_low and raw_high, the
// weighted line position becomes a signed Q8 error (ten times the position),
// and a PID term on that error moves the left and right motor duties about
// base_duty, clamped to duty_min..duty_max. One response transfer per request.
// Items are handled one at a time. A reading inside the calibration span is
// normalized by the divider; one at or outside it is set to 0 or 1000 directly.
// The position quotient has clog2(2560*(S-1)+1) bits, S = SENSOR_COUNT (13 for
// four sensors); the position division is skipped when the normalized sum is
// zero. A single restoring divider, one quotient bit a cycle, is shared by the
// normalizations and the position division. A new request is taken as soon
// as the previous result sits in the response register. Configuration must
// be written through csr_* only while no item is in work; the block itself
// does not enforce this. The 7-bit registers take the low bits of csr_data.
module line_sensor_pid_steering_unit #(
   parameter int SENSOR_COUNT = 4,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic clock,
   input  logic reset,
   // sensor_0 .. sensor_{SENSOR_COUNT-1}, SAMPLE_BITS each, from bit 0 up
   input  logic [((SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // left_duty[6:0], right_duty[13:7], position_error[27:14]
   output logic [lps_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // line_lost
   output logic rsp_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [lps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lps_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import lps_pkg::*;

   localparam int POS_QBITS = $clog2(POS_SCALE * (SENSOR_COUNT - 1) + 1);

   cmd_type                 cmd;
   sts_type                 sts;
   logic [DUTY_BITS-1:0]    left_duty, right_duty;
   logic [ERR_OUT_BITS-1:0] position_error;
   logic                    line_lost;

   assign csr_ready = 1'b1;

   lps_ctrl #(
      .POS_STEPS (POS_QBITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lps_dp #(
      .SENSOR_COUNT (SENSOR_COUNT),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .POS_QBITS    (POS_QBITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .sensors        (req_tdata[SENSOR_COUNT*SAMPLE_BITS-1:0]),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .sts            (sts),
      .left_duty      (left_duty),
      .right_duty     (right_duty),
      .position_error (position_error),
      .line_lost      (line_lost)
   );

   assign rsp_tdata = RSP_DATA_BITS'({position_error, right_duty, left_duty});
   assign rsp_tuser = line_lost;

endmodule
